>>> sv/gtl_pkg.sv
// ----------------------------------------------------------------------------
// gtl_pkg: shared types, tables and helpers for the lunar date converter
// Year table, month start table and the controller/datapath interface.
// ----------------------------------------------------------------------------
package gtl_pkg;

  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned WORD_W  = 24;
  localparam int unsigned ORD_W   = 9;   // ordinal day, 0..366
  localparam int unsigned OFF_W   = 11;  // signed day offset
  localparam int unsigned POS_W   = 4;   // month position, 0..12
  localparam int unsigned IDX_W   = 7;   // table index, 0..100

  localparam logic [YEAR_W-1:0] TABLE_FIRST_YEAR = 12'd1999;
  localparam logic [YEAR_W-1:0] RANGE_LOW        = 12'd2000;
  localparam logic [YEAR_W-1:0] RANGE_HIGH       = 12'd2099;
  localparam int unsigned       TABLE_DEPTH      = 101;
  localparam logic [POS_W-1:0]  LAST_POS         = 4'd12;
  localparam logic [MONTH_W-1:0] LAST_GREG_MONTH = 4'd11;
  localparam logic signed [OFF_W-1:0] SHORT_MONTH_DAYS = 11'sd29;
  localparam logic signed [OFF_W-1:0] COMMON_YEAR_DAYS = 11'sd365;

  // word layout
  localparam int unsigned LEAP_HI = 23;
  localparam int unsigned LEAP_LO = 20;
  localparam logic [4:0]  FIRST_LEN_BIT = 5'd19;

  // one word per year, 1999 first
  localparam logic [WORD_W-1:0] YEAR_ROM [0:TABLE_DEPTH-1] = '{
    24'h092E50, 24'h0C9645,
    24'h4D4AB8, 24'h0D4A4C, 24'h0DA541, 24'h25AAB6, 24'h056A49, 24'h7AADBD,
    24'h025D52, 24'h092D47, 24'h5C95BA, 24'h0A954E,
    24'h0B4A43, 24'h4B5537, 24'h0AD54A, 24'h955ABF, 24'h04BA53, 24'h0A5B48,
    24'h652BBC, 24'h052B50, 24'h0A9345, 24'h474AB9,
    24'h06AA4C, 24'h0AD541, 24'h24DAB6, 24'h04B64A, 24'h69573D, 24'h0A4E51,
    24'h0D2646, 24'h5E933A, 24'h0D534D, 24'h05AA43,
    24'h36B537, 24'h096D4B, 24'hB4AEBF, 24'h04AD53, 24'h0A4D48, 24'h6D25BC,
    24'h0D254F, 24'h0D5244, 24'h5DAA38, 24'h0B5A4C,
    24'h056D41, 24'h24ADB6, 24'h049B4A, 24'h7A4BBE, 24'h0A4B51, 24'h0AA546,
    24'h5B52BA, 24'h06D24E, 24'h0ADA42, 24'h355B37,
    24'h09374B, 24'h8497C1, 24'h049753, 24'h064B48, 24'h66A53C, 24'h0EA54F,
    24'h06B244, 24'h4AB638, 24'h0AAE4C, 24'h092E42,
    24'h3C9735, 24'h0C9649, 24'h7D4ABD, 24'h0D4A51, 24'h0DA545, 24'h55AABA,
    24'h056A4E, 24'h0A6D43, 24'h452EB7, 24'h052D4B,
    24'h8A95BF, 24'h0A9553, 24'h0B4A47, 24'h6B553B, 24'h0AD54F, 24'h055A45,
    24'h4A5D38, 24'h0A5B4C, 24'h052B42, 24'h3A93B6,
    24'h069349, 24'h7729BD, 24'h06AA51, 24'h0AD546, 24'h54DABA, 24'h04B64E,
    24'h0A5743, 24'h452738, 24'h0D264A, 24'h8E933E,
    24'h0D5252, 24'h0DAA47, 24'h66B53B, 24'h056D4F, 24'h04AE45, 24'h4A4EB9,
    24'h0A4D4C, 24'h0D1541, 24'h2D92B5
  };

  localparam logic [ORD_W-1:0] MONTH_START [0:11] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic load;      // capture accepted input
    logic fest;      // look up year word, compute offset
    logic use_prev;  // with fest: previous year
    logic step;      // advance one lunar month
    logic capture;   // write result register
  } gtl_cmd_t;

  typedef struct packed {
    logic in_range;
    logic off_low;   // offset before this year's festival
    logic walk_done;
  } gtl_status_t;

  function automatic logic [WORD_W-1:0] rom_word(input logic [IDX_W-1:0] idx);
    logic [WORD_W-1:0] w;
    w = '0;
    if (32'(idx) < TABLE_DEPTH) begin
      w = YEAR_ROM[idx];
    end
    return w;
  endfunction

  // month is saturated at December; leap applies from March on
  function automatic logic [ORD_W-1:0] ordinal(input logic leap,
                                               input logic [MONTH_W-1:0] m,
                                               input logic [DAY_W-1:0] d);
    logic [MONTH_W-1:0] ms;
    logic [ORD_W-1:0]   o;
    ms = (m > LAST_GREG_MONTH) ? LAST_GREG_MONTH : m;
    o  = MONTH_START[ms] + ORD_W'(d);
    if (leap && ms >= 4'd2) begin
      o = o + 9'd1;
    end
    return o;
  endfunction

endpackage

>>> sv/gtl_ctrl.sv
// ----------------------------------------------------------------------------
// gtl_ctrl: sequencer for the lunar date converter
// Steps the datapath through lookup, fallback, month walk and result write.
// ----------------------------------------------------------------------------
module gtl_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  gtl_pkg::gtl_status_t status,
  output gtl_pkg::gtl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FEST,
    S_CHECK,
    S_PREV,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:   cmd.load = in_valid;
      S_FEST:   cmd.fest = 1'b1;
      S_PREV: begin
        cmd.fest     = 1'b1;
        cmd.use_prev = 1'b1;
      end
      S_WALK:   cmd.step = !status.walk_done;
      S_FINISH: cmd.capture = slot_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE:  if (in_valid) state <= S_FEST;
        S_FEST:  state <= S_CHECK;
        S_CHECK: begin
          if (!status.in_range) begin
            state <= S_FINISH;
          end else if (status.off_low) begin
            state <= S_PREV;
          end else begin
            state <= S_WALK;
          end
        end
        S_PREV:   state <= S_WALK;
        S_WALK:   if (status.walk_done) state <= S_FINISH;
        S_FINISH: if (slot_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/gtl_dp.sv
// ----------------------------------------------------------------------------
// gtl_dp: datapath for the lunar date converter
// Ordinal day, festival offset, serial month walk and result register.
// ----------------------------------------------------------------------------
module gtl_dp (
  input  logic                               clk,
  input  logic [gtl_pkg::YEAR_W-1:0]         greg_year,
  input  logic [gtl_pkg::MONTH_W-1:0]        greg_month,
  input  logic [gtl_pkg::DAY_W-1:0]          greg_day,
  input  gtl_pkg::gtl_cmd_t                  cmd,
  output gtl_pkg::gtl_status_t               status,
  output logic [gtl_pkg::YEAR_W-1:0]         lunar_yr,
  output logic [gtl_pkg::MONTH_W-1:0]        lunar_month,
  output logic [gtl_pkg::DAY_W-1:0]          lunar_mday,
  output logic                               long_month,
  output logic                               leap_flag,
  output logic                               in_range
);

  logic [gtl_pkg::YEAR_W-1:0]        year;
  logic [gtl_pkg::ORD_W-1:0]         ord;
  logic                              range_ok;
  logic [gtl_pkg::WORD_W-1:0]        word;
  logic [gtl_pkg::YEAR_W-1:0]        ly;
  logic signed [gtl_pkg::OFF_W-1:0]  off;
  logic [gtl_pkg::POS_W-1:0]         pos;

  // lookup
  logic [gtl_pkg::YEAR_W-1:0]        sel_year;
  logic [gtl_pkg::IDX_W-1:0]         sel_idx;
  logic [gtl_pkg::WORD_W-1:0]        sel_word;
  logic                              sel_leap;
  logic [gtl_pkg::MONTH_W-1:0]       fest_month;
  logic [gtl_pkg::ORD_W-1:0]         fest_ord;
  logic signed [gtl_pkg::OFF_W-1:0]  base;
  logic signed [gtl_pkg::OFF_W-1:0]  off_new;

  // walk
  logic [4:0]                        len_bit;
  logic                              lng;
  logic signed [gtl_pkg::OFF_W-1:0]  len;
  logic                              walk_done;
  logic signed [gtl_pkg::OFF_W-1:0]  off_fin;
  logic [3:0]                        leap_pos;
  logic [gtl_pkg::MONTH_W-1:0]       month_fin;
  logic                              leap_fin;

  // every year whose result is kept lies in 1999..2099, so divisible by four is enough
  assign sel_year   = cmd.use_prev ? (year - 12'd1) : year;
  assign sel_idx    = gtl_pkg::IDX_W'(sel_year - gtl_pkg::TABLE_FIRST_YEAR);
  assign sel_word   = gtl_pkg::rom_word(sel_idx);
  assign sel_leap   = (sel_year[1:0] == 2'd0);
  assign fest_month = (sel_word[6:5] == 2'd0) ? 4'd0 : 4'({sel_word[6:5]} - 2'd1);
  assign fest_ord   = gtl_pkg::ordinal(sel_leap, fest_month, sel_word[4:0]);
  assign base       = cmd.use_prev
                      ? gtl_pkg::COMMON_YEAR_DAYS + $signed({10'd0, sel_leap})
                      : '0;
  assign off_new    = $signed({2'b00, ord}) + base - $signed({2'b00, fest_ord}) + 11'sd1;

  assign len_bit   = gtl_pkg::FIRST_LEN_BIT - {1'b0, pos};
  assign lng       = word[len_bit];
  assign len       = gtl_pkg::SHORT_MONTH_DAYS + $signed({10'd0, lng});
  assign walk_done = !(off > len) || (pos >= gtl_pkg::LAST_POS);

  assign off_fin  = (off > len) ? len : ((off < 11'sd1) ? 11'sd1 : off);
  assign leap_pos = word[gtl_pkg::LEAP_HI:gtl_pkg::LEAP_LO];

  // intercalary month keeps the number of the month it follows
  always_comb begin
    month_fin = pos;
    leap_fin  = 1'b0;
    if (leap_pos != 4'd0) begin
      if (pos == leap_pos) begin
        month_fin = pos - 4'd1;
        leap_fin  = 1'b1;
      end else if (pos > leap_pos) begin
        month_fin = pos - 4'd1;
      end
    end
  end

  assign status.in_range  = range_ok;
  assign status.off_low   = (off < 11'sd1);
  assign status.walk_done = walk_done;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year     <= greg_year;
      ord      <= gtl_pkg::ordinal(greg_year[1:0] == 2'd0, greg_month, greg_day);
      range_ok <= (greg_year >= gtl_pkg::RANGE_LOW) && (greg_year <= gtl_pkg::RANGE_HIGH);
    end
    if (cmd.fest) begin
      word <= sel_word;
      ly   <= sel_year;
      off  <= off_new;
      pos  <= '0;
    end else if (cmd.step) begin
      off <= off - len;
      pos <= pos + 4'd1;
    end
    if (cmd.capture) begin
      if (range_ok) begin
        lunar_yr    <= ly;
        lunar_month <= month_fin;
        lunar_mday  <= off_fin[gtl_pkg::DAY_W-1:0];
        long_month  <= lng;
        leap_flag   <= leap_fin;
        in_range    <= 1'b1;
      end else begin
        lunar_yr    <= '0;
        lunar_month <= '0;
        lunar_mday  <= '0;
        long_month  <= 1'b0;
        leap_flag   <= 1'b0;
        in_range    <= 1'b0;
      end
    end
  end

endmodule

>>> sv/gregorian_to_lunar_date.sv
// ----------------------------------------------------------------------------
// gregorian_to_lunar_date: Gregorian to Chinese lunar date converter
// Table lookup over 1999..2099 followed by a serial walk of month lengths.
// ----------------------------------------------------------------------------
// One date is converted at a time. A transaction on the input channel is
// taken only while the converter is idle; the result appears in an output
// register and may wait there while the next date is already being worked
// on. After the input transaction the year word is looked up and the
// festival offset formed; a date that falls before that year's Spring
// Festival looks up the previous year instead. The month walk then
// subtracts one month length per cycle until the offset fits or the last
// month is reached, and the result is written once the output register is
// free. A year outside 2000..2099 skips the lookup result and the walk.
// The next input transaction can be taken in the cycle after the result
// is written. Years outside 2000..2099 return in_range low with all other
// fields zero. A date in an intercalary month comes back with the number
// of the month it follows and leap_flag high; lunar_month is zero-based.
// ----------------------------------------------------------------------------
module gregorian_to_lunar_date (
  input  logic                        clk,
  input  logic                        rst,
  // input transaction
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gtl_pkg::YEAR_W-1:0]  greg_year,
  input  logic [gtl_pkg::MONTH_W-1:0] greg_month,
  input  logic [gtl_pkg::DAY_W-1:0]   greg_day,
  // output transaction
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gtl_pkg::YEAR_W-1:0]  lunar_yr,
  output logic [gtl_pkg::MONTH_W-1:0] lunar_month,
  output logic [gtl_pkg::DAY_W-1:0]   lunar_mday,
  output logic                        long_month,
  output logic                        leap_flag,
  output logic                        in_range
);

  gtl_pkg::gtl_cmd_t    cmd;
  gtl_pkg::gtl_status_t status;

  // sequencer: handshakes and step order
  gtl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: offset arithmetic, month walk, result register
  gtl_dp u_dp (
    .clk         (clk),
    .greg_year   (greg_year),
    .greg_month  (greg_month),
    .greg_day    (greg_day),
    .cmd         (cmd),
    .status      (status),
    .lunar_yr    (lunar_yr),
    .lunar_month (lunar_month),
    .lunar_mday  (lunar_mday),
    .long_month  (long_month),
    .leap_flag   (leap_flag),
    .in_range    (in_range)
  );

endmodule

>>> sv/gtl_checker.sv
// ----------------------------------------------------------------------------
// gtl_checker: port-level checks for the lunar date converter
// Result stability, value ranges and one-at-a-time input acceptance.
// ----------------------------------------------------------------------------
module gtl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gtl_pkg::YEAR_W-1:0]  lunar_yr,
  input logic [gtl_pkg::MONTH_W-1:0] lunar_month,
  input logic [gtl_pkg::DAY_W-1:0]   lunar_mday,
  input logic                        long_month,
  input logic                        leap_flag,
  input logic                        in_range
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(lunar_yr) &&
    $stable(lunar_month) && $stable(lunar_mday) && $stable(in_range))
    else $error("stalled result changed");

  // out-of-range year gives an all-zero result
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> lunar_yr == 12'd0 && lunar_month == 4'd0 &&
    lunar_mday == 5'd0 && !long_month && !leap_flag)
    else $error("out-of-range result not cleared");

  // day fits the reported month length
  a_day: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_range |-> lunar_mday >= 5'd1 &&
    lunar_mday <= (5'd29 + {4'd0, long_month}))
    else $error("lunar day outside month");

  // year and month within the table
  a_year: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_range |-> lunar_yr >= 12'd1999 && lunar_yr <= 12'd2099 &&
    lunar_month <= 4'd11)
    else $error("lunar year or month out of range");

  // a new date is not taken the cycle after one was taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("back-to-back input accepted");

endmodule

bind gregorian_to_lunar_date gtl_checker u_gtl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .lunar_yr    (lunar_yr),
  .lunar_month (lunar_month),
  .lunar_mday  (lunar_mday),
  .long_month  (long_month),
  .leap_flag   (leap_flag),
  .in_range    (in_range)
);
